FILE: hdl/lpp_pkg.sv
// Shared types and constants for the LED PWM pattern player.
// No dependencies; every other file in hdl/ but lpp_checker.sv refers to this package.
package lpp_pkg;

  localparam int unsigned CmdW     = 16;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned UnitsW   = 19;

  // Register map of the configuration port
  localparam logic [CfgIdxW-1:0] CFG_TICKS_PER_UNIT = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_GAP_TICKS      = 2'd1;

  localparam logic [CfgDataW-1:0] TICKS_PER_UNIT_RST = 16'd500;
  localparam logic [CfgDataW-1:0] GAP_TICKS_RST      = 16'd25;

  // PWM phase runs 0..PHASE_LAST and wraps
  localparam logic [7:0] PHASE_LAST = 8'd254;

  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_LOAD = 1'b1;

  typedef struct packed {
    logic light_on;
    logic busy_res;
    logic command_done;
    logic rejected;
  } lpp_res_t;

endpackage

FILE: hdl/lpp_if.sv
// Valid/ready channel interfaces: request, result and configuration write.
// Depends on lpp_pkg for field widths.
interface lpp_req_if;
  logic                        valid;
  logic                        ready;
  logic                        func;
  logic [lpp_pkg::CmdW-1:0]    command;
  modport source (output valid, func, command, input ready);
  modport sink   (input valid, func, command, output ready);
endinterface

interface lpp_res_if;
  logic valid;
  logic ready;
  logic light_on;
  logic busy_res;
  logic command_done;
  logic rejected;
  modport source (output valid, light_on, busy_res, command_done, rejected, input ready);
  modport sink   (input valid, light_on, busy_res, command_done, rejected, output ready);
endinterface

interface lpp_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [lpp_pkg::CfgIdxW-1:0]   index;
  logic [lpp_pkg::CfgDataW-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: hdl/lpp_core.sv
// Pattern state machine: PWM phase, unit/tick counters and gap timer.
// Updates once per accepted request; depends on lpp_pkg.
module lpp_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          acc_i,
  input  logic                          func_i,
  input  logic [lpp_pkg::CmdW-1:0]      command_i,
  input  logic [lpp_pkg::CfgDataW-1:0]  ticks_per_unit_i,
  input  logic [lpp_pkg::CfgDataW-1:0]  gap_ticks_i,
  output lpp_pkg::lpp_res_t             res_o
);

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_LIT  = 2'd1,
    MODE_GAP  = 2'd2
  } mode_e;

  mode_e                        mode_q, mode_d;
  logic [7:0]                   bright_q, bright_d;
  logic [7:0]                   phase_q, phase_d;
  logic [lpp_pkg::UnitsW-1:0]   units_q, units_d;
  logic [15:0]                  utc_q, utc_d;
  logic [15:0]                  gapc_q, gapc_d;

  logic [15:0]                  unit_lim;
  logic [16:0]                  utc_inc, gapc_inc;
  logic [lpp_pkg::UnitsW-1:0]   units_dec, units_load;
  logic                         done, rej;

  assign unit_lim   = (ticks_per_unit_i == '0) ? 16'd1 : ticks_per_unit_i;
  assign utc_inc    = {1'b0, utc_q} + 17'd1;
  assign gapc_inc   = {1'b0, gapc_q} + 17'd1;
  assign units_dec  = (units_q != '0) ? units_q - 1'b1 : '0;
  assign units_load = {15'd0, command_i[15:12]} << command_i[11:8];

  always_comb begin
    mode_d   = mode_q;
    bright_d = bright_q;
    phase_d  = phase_q;
    units_d  = units_q;
    utc_d    = utc_q;
    gapc_d   = gapc_q;
    done     = 1'b0;
    rej      = 1'b0;
    if (func_i == lpp_pkg::FUNC_LOAD) begin
      if (mode_q != MODE_IDLE) begin
        rej = 1'b1;
      end else if (command_i[15:12] != 4'd0) begin
        // top nibble zero is a loop word and is dropped
        bright_d = command_i[7:0];
        units_d  = units_load;
        utc_d    = '0;
        mode_d   = MODE_LIT;
      end
    end else begin
      phase_d = (phase_q >= lpp_pkg::PHASE_LAST) ? 8'd0 : phase_q + 8'd1;
      unique case (mode_q)
        MODE_LIT: begin
          if (utc_inc >= {1'b0, unit_lim}) begin
            utc_d   = '0;
            units_d = units_dec;
            if (units_dec == '0) begin
              gapc_d = '0;
              if (gap_ticks_i == '0) begin
                mode_d = MODE_IDLE;
                done   = 1'b1;
              end else begin
                mode_d = MODE_GAP;
              end
            end
          end else begin
            utc_d = utc_inc[15:0];
          end
        end
        MODE_GAP: begin
          if (gapc_inc >= {1'b0, gap_ticks_i}) begin
            gapc_d = '0;
            mode_d = MODE_IDLE;
            done   = 1'b1;
          end else begin
            gapc_d = gapc_inc[15:0];
          end
        end
        default: mode_d = MODE_IDLE;
      endcase
    end
  end

  always_comb begin
    res_o.light_on     = (mode_d == MODE_LIT) && (phase_d < bright_d);
    res_o.busy_res     = (mode_d != MODE_IDLE);
    res_o.command_done = done;
    res_o.rejected     = rej;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      bright_q <= '0;
      phase_q  <= '0;
      units_q  <= '0;
      utc_q    <= '0;
      gapc_q   <= '0;
    end else if (acc_i) begin
      mode_q   <= mode_d;
      bright_q <= bright_d;
      phase_q  <= phase_d;
      units_q  <= units_d;
      utc_q    <= utc_d;
      gapc_q   <= gapc_d;
    end
  end

endmodule

FILE: hdl/lpp_out_buf.sv
// Two-entry result buffer between the state update and the result channel.
// Keeps the request side flowing while one result waits; depends on lpp_pkg.
module lpp_out_buf (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  lpp_pkg::lpp_res_t  data_i,
  output logic               ready_o,
  output logic               valid_o,
  input  logic               pop_ready_i,
  output lpp_pkg::lpp_res_t  data_o
);

  lpp_pkg::lpp_res_t mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       pop;

  assign ready_o = (count_q != 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign pop     = valid_o && pop_ready_i;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop)    rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + {1'b0, push_i} - {1'b0, pop};
    end
  end

endmodule

FILE: hdl/led_pwm_pattern_player_unit.sv
// Top level of the LED PWM pattern player: config registers, core, result buffer.
// Depends on lpp_pkg, lpp_if, lpp_core and lpp_out_buf.
//
// Each request is either a tick (func 0) or a pattern command load (func 1) and
// yields exactly one result. One request is taken per clock cycle while not stalled;
// its result is registered in a two-entry output buffer, and req_i.ready drops
// only when both buffer entries hold results not yet taken. Configuration writes
// (ticks_per_unit at index 0, gap_ticks at index 1) are always ready, take effect
// on the next request, and writes to other indexes are ignored.
module led_pwm_pattern_player_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  lpp_req_if.sink    req_i,
  lpp_res_if.source  res_o,
  lpp_cfg_if.sink    cfg_i
);

  logic [lpp_pkg::CfgDataW-1:0] tpu_q, gap_q;
  logic                         req_acc, buf_ready, cfg_acc;
  lpp_pkg::lpp_res_t            core_res, buf_res;

  assign cfg_i.ready = 1'b1;
  assign cfg_acc     = cfg_i.valid && cfg_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpu_q <= lpp_pkg::TICKS_PER_UNIT_RST;
      gap_q <= lpp_pkg::GAP_TICKS_RST;
    end else if (cfg_acc) begin
      unique case (cfg_i.index)
        lpp_pkg::CFG_TICKS_PER_UNIT: tpu_q <= cfg_i.data;
        lpp_pkg::CFG_GAP_TICKS:      gap_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  assign req_i.ready = buf_ready;
  assign req_acc     = req_i.valid && buf_ready;

  lpp_core u_core (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .acc_i            (req_acc),
    .func_i           (req_i.func),
    .command_i        (req_i.command),
    .ticks_per_unit_i (tpu_q),
    .gap_ticks_i      (gap_q),
    .res_o            (core_res)
  );

  lpp_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (req_acc),
    .data_i      (core_res),
    .ready_o     (buf_ready),
    .valid_o     (res_o.valid),
    .pop_ready_i (res_o.ready),
    .data_o      (buf_res)
  );

  assign res_o.light_on     = buf_res.light_on;
  assign res_o.busy_res     = buf_res.busy_res;
  assign res_o.command_done = buf_res.command_done;
  assign res_o.rejected     = buf_res.rejected;

endmodule

FILE: hdl/lpp_checker.sv
// Port-level checks for the LED PWM pattern player, bound to the top level.
// Depends only on the top level's ports.
module lpp_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic req_valid_i,
  input logic req_ready_i,
  input logic res_valid_i,
  input logic res_ready_i,
  input logic light_on_i,
  input logic busy_res_i,
  input logic command_done_i,
  input logic rejected_i
);

  // LED can only be lit while a command runs
  a_light_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && light_on_i |-> busy_res_i)
    else $error("light_on without busy_res");

  // finishing a command leaves the block idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && command_done_i |-> !busy_res_i && !rejected_i)
    else $error("command_done with busy or rejected");

  // a refused load means the block was and stays busy
  a_rej_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && rejected_i |-> busy_res_i)
    else $error("rejected while idle");

  // a request into an empty output side shows a result next cycle
  a_res_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i && !res_valid_i |=> res_valid_i)
    else $error("result missing after request");

  // a stalled result stays put until taken
  a_res_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=>
      res_valid_i && $stable({light_on_i, busy_res_i, command_done_i, rejected_i}))
    else $error("result changed while stalled");

endmodule

bind led_pwm_pattern_player_unit lpp_checker u_lpp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .req_valid_i    (req_i.valid),
  .req_ready_i    (req_i.ready),
  .res_valid_i    (res_o.valid),
  .res_ready_i    (res_o.ready),
  .light_on_i     (res_o.light_on),
  .busy_res_i     (res_o.busy_res),
  .command_done_i (res_o.command_done),
  .rejected_i     (res_o.rejected)
);

FILE: sim/tb_led_pwm_pattern_player_unit.sv
// Testbench for led_pwm_pattern_player_unit: directed and random pattern/tick requests,
// each result checked against an in-bench model of the player state.
// Depends on hdl/lpp_pkg.sv, hdl/lpp_if.sv and the RTL under hdl/.
`timescale 1ns / 100ps

module tb_led_pwm_pattern_player_unit;

  localparam int unsigned CycleLimit = 40_000;

  typedef enum logic [1:0] {MODE_IDLE, MODE_LIT, MODE_GAP} mode_e;

  logic clk_i;
  logic rst_ni;

  lpp_req_if req_bus ();
  lpp_res_if res_bus ();
  lpp_cfg_if cfg_bus ();

  led_pwm_pattern_player_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .res_o  (res_bus),
    .cfg_i  (cfg_bus)
  );

  // Player model state and register shadow
  logic [lpp_pkg::CfgDataW-1:0] tpu_reg;
  logic [lpp_pkg::CfgDataW-1:0] gap_reg;
  mode_e                        plr_mode;
  logic [7:0]                   plr_level;
  logic [7:0]                   plr_phase;
  logic [lpp_pkg::UnitsW-1:0]   plr_units;
  logic [15:0]                  plr_unit_cnt;
  logic [15:0]                  plr_gap_cnt;

  lpp_pkg::lpp_res_t status_q[$];
  int unsigned       mismatches;
  int unsigned       cycles;
  bit                idle_en;

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("%0t: timeout with %0d results outstanding", $time, status_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Advance the model by one request and return the status it should report
  function automatic lpp_pkg::lpp_res_t player_step(input logic func,
                                                    input logic [lpp_pkg::CmdW-1:0] cmd);
    lpp_pkg::lpp_res_t r;
    logic [16:0]       unit_limit;
    logic              done;
    logic              rej;
    done = 1'b0;
    rej  = 1'b0;
    if (func == lpp_pkg::FUNC_LOAD) begin
      if (plr_mode != MODE_IDLE) begin
        rej = 1'b1;
      end else if (cmd[15:12] != 4'd0) begin
        plr_level    = cmd[7:0];
        plr_units    = lpp_pkg::UnitsW'(cmd[15:12]) << cmd[11:8];
        plr_unit_cnt = '0;
        plr_mode     = MODE_LIT;
      end
    end else begin
      plr_phase = (plr_phase >= lpp_pkg::PHASE_LAST) ? 8'd0 : plr_phase + 8'd1;
      case (plr_mode)
        MODE_LIT: begin
          unit_limit = (tpu_reg == '0) ? 17'd1 : {1'b0, tpu_reg};
          if ({1'b0, plr_unit_cnt} + 17'd1 >= unit_limit) begin
            plr_unit_cnt = '0;
            if (plr_units != '0) plr_units = plr_units - 1'b1;
            if (plr_units == '0) begin
              plr_gap_cnt = '0;
              if (gap_reg == '0) begin
                plr_mode = MODE_IDLE;
                done     = 1'b1;
              end else begin
                plr_mode = MODE_GAP;
              end
            end
          end else begin
            plr_unit_cnt = plr_unit_cnt + 16'd1;
          end
        end
        MODE_GAP: begin
          if ({1'b0, plr_gap_cnt} + 17'd1 >= {1'b0, gap_reg}) begin
            plr_gap_cnt = '0;
            plr_mode    = MODE_IDLE;
            done        = 1'b1;
          end else begin
            plr_gap_cnt = plr_gap_cnt + 16'd1;
          end
        end
        default: plr_mode = MODE_IDLE;
      endcase
    end
    r.light_on     = (plr_mode == MODE_LIT) && (plr_phase < plr_level);
    r.busy_res     = (plr_mode != MODE_IDLE);
    r.command_done = done;
    r.rejected     = rej;
    return r;
  endfunction

  // Sink side: random stalls, then compare each taken result with the oldest prediction
  always @(negedge clk_i) res_bus.ready <= !(idle_en && $urandom_range(99) < 6);

  task automatic check_field(input string fname, input logic expv, input logic actv);
    if (actv !== expv) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0b, actual %0b", $time, fname, expv, actv);
    end
  endtask

  always @(posedge clk_i) begin
    lpp_pkg::lpp_res_t want;
    if (rst_ni && res_bus.valid && res_bus.ready) begin
      if (status_q.size() == 0) begin
        mismatches++;
        $display("%0t: result with none expected, expected none, actual %b%b%b%b", $time,
                 res_bus.light_on, res_bus.busy_res, res_bus.command_done, res_bus.rejected);
      end else begin
        want = status_q.pop_front();
        check_field("light_on", want.light_on, res_bus.light_on);
        check_field("busy_res", want.busy_res, res_bus.busy_res);
        check_field("command_done", want.command_done, res_bus.command_done);
        check_field("rejected", want.rejected, res_bus.rejected);
      end
    end
  end

  // All request tasks start and end at a falling edge
  task automatic send_req(input logic func, input logic [lpp_pkg::CmdW-1:0] cmd);
    while (idle_en && $urandom_range(99) < 6) begin
      req_bus.valid   = 1'b0;
      req_bus.func    = 1'($urandom_range(1));
      req_bus.command = 16'($urandom);
      @(negedge clk_i);
    end
    req_bus.valid   = 1'b1;
    req_bus.func    = func;
    req_bus.command = cmd;
    @(posedge clk_i);
    while (!req_bus.ready) @(posedge clk_i);
    status_q.push_back(player_step(func, cmd));
    @(negedge clk_i);
  endtask

  task automatic send_ticks(input int unsigned n);
    repeat (n) send_req(lpp_pkg::FUNC_TICK, 16'($urandom));
  endtask

  task automatic tick_until_idle();
    do send_req(lpp_pkg::FUNC_TICK, 16'($urandom)); while (plr_mode != MODE_IDLE);
  endtask

  task automatic drain_results();
    req_bus.valid = 1'b0;
    while (status_q.size() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [lpp_pkg::CfgIdxW-1:0] idx,
                           input logic [lpp_pkg::CfgDataW-1:0] val);
    cfg_bus.valid = 1'b1;
    cfg_bus.index = idx;
    cfg_bus.data  = val;
    @(posedge clk_i);
    while (!cfg_bus.ready) @(posedge clk_i);
    if (idx == lpp_pkg::CFG_TICKS_PER_UNIT) tpu_reg = val;
    else if (idx == lpp_pkg::CFG_GAP_TICKS) gap_reg = val;
    @(negedge clk_i);
    cfg_bus.valid = 1'b0;
  endtask

  task automatic set_timing(input logic [lpp_pkg::CfgDataW-1:0] tpu,
                            input logic [lpp_pkg::CfgDataW-1:0] gap);
    drain_results();
    write_reg(lpp_pkg::CFG_TICKS_PER_UNIT, tpu);
    write_reg(lpp_pkg::CFG_GAP_TICKS, gap);
  endtask

  // Mostly short durations so many commands complete; brightness hits its ends often
  function automatic logic [lpp_pkg::CmdW-1:0] random_pattern();
    logic [3:0] base;
    logic [3:0] sh;
    logic [7:0] lvl;
    base = ($urandom_range(99) < 75) ? 4'($urandom_range(1, 3)) : 4'($urandom_range(1, 15));
    sh   = ($urandom_range(99) < 85) ? 4'd0 : 4'($urandom_range(1, 3));
    case ($urandom_range(9))
      0:       lvl = 8'd0;
      1:       lvl = 8'hff;
      2:       lvl = 8'($urandom_range(1, 2));
      default: lvl = 8'($urandom);
    endcase
    return {base, sh, lvl};
  endfunction

  // Reset register values; loop words idle and busy; loads refused while busy
  task automatic test_reset_timing();
    send_ticks(3);
    send_req(lpp_pkg::FUNC_LOAD, 16'h0000);
    send_req(lpp_pkg::FUNC_LOAD, 16'h0fff);
    send_req(lpp_pkg::FUNC_LOAD, 16'h10ff);
    send_ticks(5);
    send_req(lpp_pkg::FUNC_LOAD, 16'hffff);
    send_req(lpp_pkg::FUNC_LOAD, 16'h0abc);
    tick_until_idle();
    send_ticks(2);
  endtask

  // Zero ticks per unit behaves as one; zero gap ends on the last lit tick
  task automatic test_zero_registers();
    set_timing(16'd0, 16'd0);
    send_req(lpp_pkg::FUNC_LOAD, 16'h2180);
    tick_until_idle();
    send_req(lpp_pkg::FUNC_LOAD, 16'h1000);
    tick_until_idle();
    send_req(lpp_pkg::FUNC_LOAD, 16'h3201);
    send_req(lpp_pkg::FUNC_LOAD, 16'h1234);
    tick_until_idle();
  endtask

  // Lowering a limit below a running count ends the running unit or gap on the next tick
  task automatic test_midrun_writes();
    set_timing(16'd20, 16'd30);
    send_req(lpp_pkg::FUNC_LOAD, 16'h2040);
    send_ticks(12);
    drain_results();
    write_reg(lpp_pkg::CFG_TICKS_PER_UNIT, 16'd5);
    do send_req(lpp_pkg::FUNC_TICK, 16'($urandom)); while (plr_mode == MODE_LIT);
    send_ticks(10);
    drain_results();
    write_reg(lpp_pkg::CFG_GAP_TICKS, 16'd4);
    tick_until_idle();
    send_ticks(2);
  endtask

  // Full-range registers cut short by a lower write; the largest duration is
  // loaded and left running, so later loads are refused
  task automatic test_long_counts();
    set_timing(16'hffff, 16'd1);
    send_req(lpp_pkg::FUNC_LOAD, 16'h1001);
    send_ticks(40);
    drain_results();
    write_reg(lpp_pkg::CFG_TICKS_PER_UNIT, 16'd3);
    tick_until_idle();
    set_timing(16'd1, 16'hffff);
    send_req(lpp_pkg::FUNC_LOAD, 16'h11fe);
    send_ticks(40);
    drain_results();
    write_reg(lpp_pkg::CFG_GAP_TICKS, 16'd2);
    tick_until_idle();
    set_timing(16'd1, 16'd0);
    send_req(lpp_pkg::FUNC_LOAD, 16'hf0c0);
    tick_until_idle();
    send_req(lpp_pkg::FUNC_LOAD, 16'hff55);
    send_ticks(60);
    send_req(lpp_pkg::FUNC_LOAD, 16'h1234);
    send_ticks(4);
  endtask

  task automatic test_random_patterns(input int unsigned n,
                                      input logic [lpp_pkg::CfgDataW-1:0] tpu,
                                      input logic [lpp_pkg::CfgDataW-1:0] gap,
                                      input bit calm);
    int unsigned roll;
    set_timing(tpu, gap);
    idle_en = !calm;
    for (int unsigned k = 0; k < n; k++) begin
      roll = $urandom_range(99);
      if (plr_mode == MODE_IDLE && roll < 35) begin
        send_req(lpp_pkg::FUNC_LOAD, random_pattern());
      end else if (plr_mode == MODE_IDLE && roll < 42) begin
        send_req(lpp_pkg::FUNC_LOAD, {4'h0, 12'($urandom)});
      end else if (plr_mode != MODE_IDLE && roll < 5) begin
        send_req(lpp_pkg::FUNC_LOAD, 16'($urandom));
      end else begin
        send_req(lpp_pkg::FUNC_TICK, 16'($urandom));
      end
    end
    drain_results();
    idle_en = 1'b1;
  endtask

  initial begin
    rst_ni          = 1'b0;
    idle_en         = 1'b1;
    mismatches      = 0;
    cycles          = 0;
    req_bus.valid   = 1'b0;
    req_bus.func    = lpp_pkg::FUNC_TICK;
    req_bus.command = '0;
    cfg_bus.valid   = 1'b0;
    cfg_bus.index   = lpp_pkg::CFG_TICKS_PER_UNIT;
    cfg_bus.data    = '0;
    res_bus.ready   = 1'b0;
    tpu_reg         = lpp_pkg::TICKS_PER_UNIT_RST;
    gap_reg         = lpp_pkg::GAP_TICKS_RST;
    plr_mode        = MODE_IDLE;
    plr_level       = '0;
    plr_phase       = '0;
    plr_units       = '0;
    plr_unit_cnt    = '0;
    plr_gap_cnt     = '0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_reset_timing();
    test_zero_registers();
    test_midrun_writes();
    test_random_patterns(200, 16'd1, 16'd0, 1'b0);
    test_random_patterns(200, 16'd0, 16'd1, 1'b0);
    test_random_patterns(200, 16'd3, 16'd2, 1'b0);
    test_random_patterns(200, 16'd2, 16'd5, 1'b1);
    test_random_patterns(200, 16'($urandom_range(1, 6)), 16'($urandom_range(0, 8)), 1'b0);
    test_random_patterns(200, 16'd4, 16'd3, 1'b0);
    test_long_counts();

    drain_results();
    repeat (8) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
